// File: src/pf_pkg.sv
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared types, constants and helper functions for the digraph cipher.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int SIDE   = 5;
    localparam int CODE_W = 5;
    localparam int ROW_W  = SIDE * CODE_W;
    localparam int POS_W  = 3;
    localparam int IDX_W  = 3;

    typedef logic [CODE_W-1:0]           t_code;
    typedef logic [POS_W-1:0]            t_posidx;
    typedef logic [ROW_W-1:0]            t_row;
    typedef logic [SIDE-1:0][ROW_W-1:0]  t_square;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_ROW_ZERO  = 3'd0,
        REG_ROW_ONE   = 3'd1,
        REG_ROW_TWO   = 3'd2,
        REG_ROW_THREE = 3'd3,
        REG_ROW_FOUR  = 3'd4,
        REG_DIRECTION = 3'd5
    } t_cfg_idx;

    // Reset square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z.
    localparam t_row ROW0_RST = t_row'(4294688);
    localparam t_row ROW1_RST = t_row'(10755269);
    localparam t_row ROW2_RST = t_row'(16201099);
    localparam t_row ROW3_RST = t_row'(21613104);
    localparam t_row ROW4_RST = t_row'(27025109);

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam t_posidx POS_LAST = t_posidx'(SIDE - 1);

    // Position of one located letter.
    typedef struct packed {
        logic    found;
        t_posidx row;
        t_posidx col;
    } t_pos;

    // Target cells of both output letters.
    typedef struct packed {
        logic    not_found;
        t_posidx row1;
        t_posidx col1;
        t_posidx row2;
        t_posidx col2;
    } t_target;

    function automatic t_posidx step_fwd(input t_posidx p);
        return (p == POS_LAST) ? '0 : t_posidx'(p + 1'b1);
    endfunction

    function automatic t_posidx step_back(input t_posidx p);
        return (p == '0) ? POS_LAST : t_posidx'(p - 1'b1);
    endfunction

    function automatic t_code cell_at(input t_square sq, input t_posidx row,
                                      input t_posidx col);
        t_row r;
        r = sq[row];
        return r[col * CODE_W +: CODE_W];
    endfunction

endpackage

// File: src/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Four-stage pipeline that substitutes one letter pair per clock cycle
// using a 5x5 key square held in configuration registers.
// ----------------------------------------------------------------------------
// Usage:
// A digraph transfer happens at a rising edge where i_start is high and
// o_busy is low. o_busy is tied low, so a new pair can enter every cycle.
// The result appears on o_out_first, o_out_second and o_not_found with
// o_valid high for exactly one cycle, once the pair has passed all four
// register stages. Throughput is one pair per cycle; the four register
// stages are cell compare, last-match encode, rule selection and final
// cell lookup. The receiver cannot stall the output, and none of the
// stages ever needs to hold.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) writes square rows 0 to 4 and the direction bit (index 5);
// o_cfg_ready is always high and other indexes are ignored. Write it only
// while no pair is in flight.
// Reset (synchronous, active low) loads the alphabet square without j,
// selects encryption and clears all pipeline valid bits.
// A letter missing from the square yields zeros and o_not_found high.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  pf_pkg::t_code        i_first_letter,
    input  pf_pkg::t_code        i_second_letter,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  pf_pkg::t_row         i_cfg_data,
    output logic                 o_valid,
    output pf_pkg::t_code        o_out_first,
    output pf_pkg::t_code        o_out_second,
    output logic                 o_not_found
);
    import pf_pkg::*;

    localparam int DEPTH = 4;

    t_square          r_square;
    logic             r_dir;
    logic [DEPTH-1:0] r_vld;
    t_pos             pos1;
    t_pos             pos2;
    t_target          target;
    t_code            r_out_first;
    t_code            r_out_second;
    logic             r_not_found;
    t_code            n_out_first;
    t_code            n_out_second;

    // The pipeline never holds, so both channels are always ready.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square[0] <= ROW0_RST;
            r_square[1] <= ROW1_RST;
            r_square[2] <= ROW2_RST;
            r_square[3] <= ROW3_RST;
            r_square[4] <= ROW4_RST;
            r_dir       <= DIR_ENCRYPT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_ROW_ZERO:  r_square[0] <= i_cfg_data;
                REG_ROW_ONE:   r_square[1] <= i_cfg_data;
                REG_ROW_TWO:   r_square[2] <= i_cfg_data;
                REG_ROW_THREE: r_square[3] <= i_cfg_data;
                REG_ROW_FOUR:  r_square[4] <= i_cfg_data;
                REG_DIRECTION: r_dir       <= i_cfg_data[0];
                default:       r_dir       <= r_dir;
            endcase
        end
    end

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], i_start && !o_busy};
        end
    end

    // Stages one and two: locate each letter.
    pf_match u_match_first (
        .i_clk    (i_clk),
        .i_letter (i_first_letter),
        .i_square (r_square),
        .o_pos    (pos1)
    );

    pf_match u_match_second (
        .i_clk    (i_clk),
        .i_letter (i_second_letter),
        .i_square (r_square),
        .o_pos    (pos2)
    );

    // Stage three: pick the substitution rule and target cells.
    pf_rule u_rule (
        .i_clk    (i_clk),
        .i_pos1   (pos1),
        .i_pos2   (pos2),
        .i_dir    (r_dir),
        .o_target (target)
    );

    // Stage four: read the target cells, forcing zeros when a letter was
    // missing from the square.
    always_comb begin
        n_out_first  = cell_at(r_square, target.row1, target.col1);
        n_out_second = cell_at(r_square, target.row2, target.col2);
        if (target.not_found) begin
            n_out_first  = '0;
            n_out_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_not_found  <= target.not_found;
    end

    assign o_valid      = r_vld[DEPTH-1];
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;
    assign o_not_found  = r_not_found;

endmodule

// File: src/pf_match.sv
// ----------------------------------------------------------------------------
// Playfair letter locator
// Compares one letter against all 25 square cells, then encodes the last
// match in row-major order into a row and column. Two register stages.
// ----------------------------------------------------------------------------
module pf_match (
    input  logic            i_clk,
    input  pf_pkg::t_code   i_letter,
    input  pf_pkg::t_square i_square,
    output pf_pkg::t_pos    o_pos
);
    import pf_pkg::*;

    logic [SIDE-1:0][SIDE-1:0] r_hit;
    logic [SIDE-1:0][SIDE-1:0] n_hit;
    logic [SIDE-1:0]           row_any;
    t_pos                      r_pos;
    t_pos                      n_pos;

    always_comb begin
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                n_hit[r][c] = (cell_at(i_square, t_posidx'(r), t_posidx'(c)) == i_letter);
            end
        end
    end

    // The highest row holding a match, then the highest column in that row,
    // gives the last match in row-major order.
    always_comb begin
        n_pos = '0;
        for (int r = 0; r < SIDE; r++) begin
            row_any[r] = |r_hit[r];
            if (row_any[r]) begin
                n_pos.row   = t_posidx'(r);
                n_pos.found = 1'b1;
            end
        end
        for (int c = 0; c < SIDE; c++) begin
            if (r_hit[n_pos.row][c]) begin
                n_pos.col = t_posidx'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
        r_pos <= n_pos;
    end

    assign o_pos = r_pos;

endmodule

// File: src/pf_rule.sv
// ----------------------------------------------------------------------------
// Playfair substitution rule
// Chooses the same-row, same-column or rectangle rule and registers the
// target cells of both output letters.
// ----------------------------------------------------------------------------
module pf_rule (
    input  logic            i_clk,
    input  pf_pkg::t_pos    i_pos1,
    input  pf_pkg::t_pos    i_pos2,
    input  logic            i_dir,
    output pf_pkg::t_target o_target
);
    import pf_pkg::*;

    t_target r_target;
    t_target n_target;

    always_comb begin
        n_target           = '0;
        n_target.not_found = !(i_pos1.found && i_pos2.found);
        if (i_pos1.row == i_pos2.row) begin
            n_target.row1 = i_pos1.row;
            n_target.row2 = i_pos2.row;
            n_target.col1 = (i_dir == DIR_DECRYPT) ? step_back(i_pos1.col)
                                                   : step_fwd(i_pos1.col);
            n_target.col2 = (i_dir == DIR_DECRYPT) ? step_back(i_pos2.col)
                                                   : step_fwd(i_pos2.col);
        end else if (i_pos1.col == i_pos2.col) begin
            n_target.col1 = i_pos1.col;
            n_target.col2 = i_pos2.col;
            n_target.row1 = (i_dir == DIR_DECRYPT) ? step_back(i_pos1.row)
                                                   : step_fwd(i_pos1.row);
            n_target.row2 = (i_dir == DIR_DECRYPT) ? step_back(i_pos2.row)
                                                   : step_fwd(i_pos2.row);
        end else begin
            n_target.row1 = i_pos1.row;
            n_target.col1 = i_pos2.col;
            n_target.row2 = i_pos2.row;
            n_target.col2 = i_pos1.col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target <= n_target;
    end

    assign o_target = r_target;

endmodule
